/* design/launcher_load_spool_fire_sequencer_core_defines.svh */
// ----------------------------------------------------------------------------
// Launcher sequencer assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef LAUNCHER_LOAD_SPOOL_FIRE_SEQUENCER_CORE_DEFINES_SVH
`define LAUNCHER_LOAD_SPOOL_FIRE_SEQUENCER_CORE_DEFINES_SVH

// same-cycle implication
`define LSFS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LSFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/lsfs_pkg.sv */
// ----------------------------------------------------------------------------
// lsfs_pkg
// Types, register map and reset values for the launcher sequencer.
// ----------------------------------------------------------------------------
package lsfs_pkg;

	localparam int TIMER_BITS_DEF = 16;
	localparam int DRIVE_BITS_DEF = 16;
	localparam int CFG_ADDR_BITS  = 5;
	localparam int CFG_DATA_BITS  = 32;

	localparam logic signed [15:0] SPEED_RST       = 16'sd0;
	localparam logic [15:0]        UNLOAD_SPOOL_RST = 16'd25;
	localparam logic [15:0]        SHOOT_SPOOL_RST  = 16'd125;
	localparam logic [15:0]        PULSE_RST        = 16'd25;

	typedef enum logic [2:0] {
		MODE_UNINIT       = 3'd0,
		MODE_IDLE         = 3'd1,
		MODE_LOADING      = 3'd2,
		MODE_LOADED       = 3'd3,
		MODE_UNLOADING    = 3'd4,
		MODE_SHOOTING     = 3'd5,
		MODE_UNLOAD_PULSE = 3'd6,
		MODE_SHOOT_PULSE  = 3'd7
	} mode_t;

	typedef enum logic [2:0] {
		REG_IDLE_SPEED   = 3'd0,
		REG_LOAD_SPEED   = 3'd1,
		REG_UNLOAD_SPEED = 3'd2,
		REG_SHOOT_SPEED  = 3'd3,
		REG_UNLOAD_SPOOL = 3'd4,
		REG_SHOOT_SPOOL  = 3'd5,
		REG_PULSE_TICKS  = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic load_press;
		logic loaded_press;
		logic unload_press;
		logic shoot_press;
		logic idle_press;
		logic ball_switch_n;
	} item_in_t;

	typedef struct packed {
		logic [2:0]          mode_out;
		logic signed [15:0]  wheel_drive;
		logic                kicker_extend;
		logic                ball_present;
	} item_out_t;

	typedef struct packed {
		logic signed [15:0] idle_speed;
		logic signed [15:0] load_speed;
		logic signed [15:0] unload_speed;
		logic signed [15:0] shoot_speed;
		logic [15:0]        unload_spool_ticks;
		logic [15:0]        shoot_spool_ticks;
		logic [15:0]        pulse_ticks;
	} cfg_t;

	typedef struct packed {
		mode_t mode;
		logic  ball_held;
		logic  kicker;
	} ctl_state_t;

endpackage

/* design/launcher_load_spool_fire_sequencer_core.sv */
// ----------------------------------------------------------------------------
// launcher_load_spool_fire_sequencer_core
// Launcher load / spool / fire sequencer: one control tick per transaction.
// ----------------------------------------------------------------------------
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+--------------------------------
//  in       | in_valid / in_stall        | in_data  (lsfs_pkg::item_in_t)
//  out      | out_valid / out_stall      | out_data (lsfs_pkg::item_out_t)
//  cfg      | APB psel/penable/pwrite    | paddr, pwdata, prdata, pready
//
//  One transaction per clock sustained while out_stall is low; the path is
//  input register, tick logic, result register.
//  Tick logic is a single short pass: a 16-bit timer compare, a speed clamp
//  and the mode case.
//  Reset (arst_n low) puts the mode in uninit, drops the ball flag, zeroes
//  timer and drive, retracts the kicker and loads register defaults.
//  A stalled result holds the result register; the input register takes a
//  new transaction whenever the result register is free or being drained.
// ----------------------------------------------------------------------------
`include "launcher_load_spool_fire_sequencer_core_defines.svh"

module launcher_load_spool_fire_sequencer_core #(
	parameter int TIMER_BITS = lsfs_pkg::TIMER_BITS_DEF,
	parameter int DRIVE_BITS = lsfs_pkg::DRIVE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                in_valid,
	output logic                                in_stall,
	input  lsfs_pkg::item_in_t                  in_data,

	output logic                                out_valid,
	input  logic                                out_stall,
	output lsfs_pkg::item_out_t                 out_data,

	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [lsfs_pkg::CFG_ADDR_BITS-1:0]  paddr,
	input  logic [lsfs_pkg::CFG_DATA_BITS-1:0]  pwdata,
	output logic [lsfs_pkg::CFG_DATA_BITS-1:0]  prdata,
	output logic                                pready
);

	lsfs_pkg::cfg_t        cfg;

	// stage 1: captured tick
	logic                  valid_s1;
	lsfs_pkg::item_in_t    item_s1;

	// stage 2: result register
	logic                  out_valid_s2;
	lsfs_pkg::item_out_t   out_data_s2;

	// sequencer state
	lsfs_pkg::ctl_state_t         state_q;
	logic [TIMER_BITS-1:0]        elapsed_q;
	logic signed [DRIVE_BITS-1:0] drive_q;

	lsfs_pkg::ctl_state_t         state_nxt;
	logic [TIMER_BITS-1:0]        elapsed_nxt;
	logic signed [DRIVE_BITS-1:0] drive_nxt;
	lsfs_pkg::item_out_t          result;

	logic                  advance;   // result register can take stage 1
	logic                  tick_fire; // stage 1 transaction is processed now

	// mode groups watched by the checks below
	logic                  pulse_mode;
	logic                  fire_mode;
	logic                  spool_start;

	lsfs_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lsfs_step #(
		.TIMER_BITS (TIMER_BITS),
		.DRIVE_BITS (DRIVE_BITS)
	) u_step (
		.item        (item_s1),
		.cfg         (cfg),
		.cur         (state_q),
		.elapsed     (elapsed_q),
		.drive       (drive_q),
		.nxt         (state_nxt),
		.elapsed_nxt (elapsed_nxt),
		.drive_nxt   (drive_nxt),
		.result      (result)
	);

	assign advance   = !out_valid_s2 || !out_stall;
	assign tick_fire = valid_s1 && advance;
	assign in_stall  = valid_s1 && !advance;
	assign out_valid = out_valid_s2;
	assign out_data  = out_data_s2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_fire) begin
			out_data_s2 <= result;
		end
	end

	// state advances once per processed tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode      <= lsfs_pkg::MODE_UNINIT;
			state_q.ball_held <= 1'b0;
			state_q.kicker    <= 1'b0;
			elapsed_q         <= '0;
			drive_q           <= '0;
		end else if (tick_fire) begin
			state_q   <= state_nxt;
			elapsed_q <= elapsed_nxt;
			drive_q   <= drive_nxt;
		end
	end

	assign pulse_mode  = (state_q.mode == lsfs_pkg::MODE_UNLOAD_PULSE) ||
	                     (state_q.mode == lsfs_pkg::MODE_SHOOT_PULSE);
	assign fire_mode   = pulse_mode || (state_q.mode == lsfs_pkg::MODE_UNLOADING) ||
	                     (state_q.mode == lsfs_pkg::MODE_SHOOTING);
	assign spool_start = tick_fire && (state_q.mode == lsfs_pkg::MODE_LOADED) &&
	                     (state_nxt.mode != lsfs_pkg::MODE_LOADED);

	// kicker is out exactly during the two pulse modes
	`LSFS_ASSERT_NOW(a_kicker_pulse, clk, arst_n, 1'b1, state_q.kicker == pulse_mode, "kicker vs mode")
	// spool and pulse modes are only reachable with a held ball
	`LSFS_ASSERT_NOW(a_ball_in_fire, clk, arst_n, fire_mode, state_q.ball_held, "fire without ball")
	// leaving loaded for a spool restarts the timer
	`LSFS_ASSERT_NEXT(a_spool_restart, clk, arst_n, spool_start, elapsed_q == '0, "no timer restart")

endmodule

/* design/lsfs_cfg_regs.sv */
// ----------------------------------------------------------------------------
// lsfs_cfg_regs
// APB register file holding wheel speeds and tick counts.
// ----------------------------------------------------------------------------
module lsfs_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [lsfs_pkg::CFG_ADDR_BITS-1:0]  paddr,
	input  logic [lsfs_pkg::CFG_DATA_BITS-1:0]  pwdata,
	output logic [lsfs_pkg::CFG_DATA_BITS-1:0]  prdata,
	output logic                                pready,
	output lsfs_pkg::cfg_t                      cfg
);

	lsfs_pkg::cfg_t     cfg_q;
	lsfs_pkg::reg_idx_t idx;
	logic               wr_en;

	assign idx    = lsfs_pkg::reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.idle_speed         <= lsfs_pkg::SPEED_RST;
			cfg_q.load_speed         <= lsfs_pkg::SPEED_RST;
			cfg_q.unload_speed       <= lsfs_pkg::SPEED_RST;
			cfg_q.shoot_speed        <= lsfs_pkg::SPEED_RST;
			cfg_q.unload_spool_ticks <= lsfs_pkg::UNLOAD_SPOOL_RST;
			cfg_q.shoot_spool_ticks  <= lsfs_pkg::SHOOT_SPOOL_RST;
			cfg_q.pulse_ticks        <= lsfs_pkg::PULSE_RST;
		end else if (wr_en) begin
			case (idx)
				lsfs_pkg::REG_IDLE_SPEED:   cfg_q.idle_speed         <= pwdata[15:0];
				lsfs_pkg::REG_LOAD_SPEED:   cfg_q.load_speed         <= pwdata[15:0];
				lsfs_pkg::REG_UNLOAD_SPEED: cfg_q.unload_speed       <= pwdata[15:0];
				lsfs_pkg::REG_SHOOT_SPEED:  cfg_q.shoot_speed        <= pwdata[15:0];
				lsfs_pkg::REG_UNLOAD_SPOOL: cfg_q.unload_spool_ticks <= pwdata[15:0];
				lsfs_pkg::REG_SHOOT_SPOOL:  cfg_q.shoot_spool_ticks  <= pwdata[15:0];
				lsfs_pkg::REG_PULSE_TICKS:  cfg_q.pulse_ticks        <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			lsfs_pkg::REG_IDLE_SPEED:   prdata = {16'd0, cfg_q.idle_speed};
			lsfs_pkg::REG_LOAD_SPEED:   prdata = {16'd0, cfg_q.load_speed};
			lsfs_pkg::REG_UNLOAD_SPEED: prdata = {16'd0, cfg_q.unload_speed};
			lsfs_pkg::REG_SHOOT_SPEED:  prdata = {16'd0, cfg_q.shoot_speed};
			lsfs_pkg::REG_UNLOAD_SPOOL: prdata = {16'd0, cfg_q.unload_spool_ticks};
			lsfs_pkg::REG_SHOOT_SPOOL:  prdata = {16'd0, cfg_q.shoot_spool_ticks};
			lsfs_pkg::REG_PULSE_TICKS:  prdata = {16'd0, cfg_q.pulse_ticks};
			default:                    prdata = '0;
		endcase
	end

endmodule

/* design/lsfs_step.sv */
// ----------------------------------------------------------------------------
// lsfs_step
// One control tick: mode transition, timer, drive, kicker and ball flag.
// ----------------------------------------------------------------------------
module lsfs_step #(
	parameter int TIMER_BITS = lsfs_pkg::TIMER_BITS_DEF,
	parameter int DRIVE_BITS = lsfs_pkg::DRIVE_BITS_DEF
) (
	input  lsfs_pkg::item_in_t             item,
	input  lsfs_pkg::cfg_t                 cfg,
	input  lsfs_pkg::ctl_state_t           cur,
	input  logic [TIMER_BITS-1:0]          elapsed,
	input  logic signed [DRIVE_BITS-1:0]   drive,
	output lsfs_pkg::ctl_state_t           nxt,
	output logic [TIMER_BITS-1:0]          elapsed_nxt,
	output logic signed [DRIVE_BITS-1:0]   drive_nxt,
	output lsfs_pkg::item_out_t            result
);

	localparam logic signed [31:0] DRV_HI = (32'sd1 <<< (DRIVE_BITS - 1)) - 32'sd1;
	localparam logic signed [31:0] DRV_LO = -DRV_HI - 32'sd1;

	logic [TIMER_BITS-1:0] elapsed_inc;
	logic [31:0]           elapsed_w;
	logic                  shooting;
	logic [15:0]           spool_wait;
	logic                  fire;
	logic                  spool_done;
	logic                  pulse_done;
	logic                  ball_at_sensor;
	logic                  set_drive;
	logic signed [15:0]    speed_sel;
	logic signed [31:0]    speed_ext;
	logic signed [31:0]    speed_lim;
	logic signed [31:0]    drive_ext;
	lsfs_pkg::mode_t       mode_nxt;
	logic                  ball_nxt;
	logic                  kick_nxt;

	// saturating tick count; this tick compares against the counted-up value
	assign elapsed_inc    = (&elapsed) ? elapsed : elapsed + 1'b1;
	assign elapsed_w      = 32'(elapsed_inc);
	assign shooting       = (cur.mode == lsfs_pkg::MODE_SHOOTING);
	assign spool_wait     = shooting ? cfg.shoot_spool_ticks : cfg.unload_spool_ticks;
	assign fire           = shooting ? item.shoot_press : item.unload_press;
	assign spool_done     = elapsed_w >= 32'(spool_wait);
	assign pulse_done     = elapsed_w >= 32'(cfg.pulse_ticks);
	assign ball_at_sensor = ~item.ball_switch_n;

	// next mode
	always_comb begin
		mode_nxt = cur.mode;
		case (cur.mode)
			lsfs_pkg::MODE_UNINIT:
				mode_nxt = cur.ball_held ? lsfs_pkg::MODE_LOADED : lsfs_pkg::MODE_IDLE;
			lsfs_pkg::MODE_IDLE: begin
				if (item.load_press)        mode_nxt = lsfs_pkg::MODE_LOADING;
				else if (item.loaded_press) mode_nxt = lsfs_pkg::MODE_LOADED;
			end
			lsfs_pkg::MODE_LOADING: begin
				if (item.load_press || item.idle_press) mode_nxt = lsfs_pkg::MODE_IDLE;
				else if (ball_at_sensor)                mode_nxt = lsfs_pkg::MODE_LOADED;
			end
			lsfs_pkg::MODE_LOADED: begin
				if (item.unload_press)     mode_nxt = lsfs_pkg::MODE_UNLOADING;
				else if (item.shoot_press) mode_nxt = lsfs_pkg::MODE_SHOOTING;
			end
			lsfs_pkg::MODE_UNLOADING, lsfs_pkg::MODE_SHOOTING: begin
				if (spool_done) begin
					if (fire)
						mode_nxt = shooting ? lsfs_pkg::MODE_SHOOT_PULSE
						                    : lsfs_pkg::MODE_UNLOAD_PULSE;
				end else if (item.idle_press) begin
					mode_nxt = lsfs_pkg::MODE_LOADED;
				end
			end
			lsfs_pkg::MODE_UNLOAD_PULSE, lsfs_pkg::MODE_SHOOT_PULSE: begin
				if (pulse_done) mode_nxt = lsfs_pkg::MODE_IDLE;
			end
			default: mode_nxt = cur.mode;
		endcase
	end

	// timer, drive, kicker and ball flag
	always_comb begin
		ball_nxt    = cur.ball_held;
		kick_nxt    = cur.kicker;
		elapsed_nxt = elapsed_inc;
		set_drive   = 1'b0;
		speed_sel   = cfg.idle_speed;
		case (cur.mode)
			lsfs_pkg::MODE_IDLE: set_drive = 1'b1;
			lsfs_pkg::MODE_LOADING: begin
				kick_nxt  = 1'b0;
				set_drive = 1'b1;
				speed_sel = cfg.load_speed;
			end
			lsfs_pkg::MODE_LOADED: begin
				set_drive = 1'b1;
				ball_nxt  = 1'b1;
				if (item.unload_press || item.shoot_press) elapsed_nxt = '0;
			end
			lsfs_pkg::MODE_UNLOADING, lsfs_pkg::MODE_SHOOTING: begin
				set_drive = 1'b1;
				speed_sel = shooting ? cfg.shoot_speed : cfg.unload_speed;
				if (spool_done) begin
					if (fire) begin
						elapsed_nxt = '0;
						kick_nxt    = 1'b1;
					end
				end else if (item.idle_press) begin
					elapsed_nxt = '0;
				end
			end
			lsfs_pkg::MODE_UNLOAD_PULSE, lsfs_pkg::MODE_SHOOT_PULSE: begin
				if (pulse_done) begin
					ball_nxt    = 1'b0;
					kick_nxt    = 1'b0;
					set_drive   = 1'b1;
					elapsed_nxt = '0;
				end
			end
			default: ;
		endcase
	end

	assign nxt = '{mode: mode_nxt, ball_held: ball_nxt, kicker: kick_nxt};

	// limit the register value to the drive range, then hold or replace
	assign speed_ext = 32'(speed_sel);
	assign speed_lim = (speed_ext > DRV_HI) ? DRV_HI :
	                   (speed_ext < DRV_LO) ? DRV_LO : speed_ext;
	assign drive_nxt = set_drive ? speed_lim[DRIVE_BITS-1:0] : drive;
	assign drive_ext = 32'(drive_nxt);

	assign result.mode_out      = mode_nxt;
	assign result.wheel_drive   = drive_ext[15:0];
	assign result.kicker_extend = kick_nxt;
	assign result.ball_present  = ball_nxt;

endmodule
